### hdl/gpp_pkg.sv
package gpp_pkg;

   // Fixed field widths
   localparam int PIX_W       = 12;
   localparam int ANGLE_BITS  = 10;
   localparam int QUARTER     = 1 << (ANGLE_BITS - 2);
   localparam int TRIG_FRAC   = 22;
   localparam int TRIG_W      = TRIG_FRAC + 2;   // signed sine/cosine
   localparam int COORD_W     = 32;
   localparam int HEIGHT_W    = 31;
   localparam int HORIZON_W   = PIX_W + 1;
   localparam int OFS_W       = PIX_W + 2;       // signed column/row offsets
   localparam int DEN_W       = PIX_W + 1;       // divisor width of both dividers
   localparam int NUM1_W      = PIX_W + HEIGHT_W;      // distance * height
   localparam int NUM2_W      = DEN_W + NUM1_W;        // |rx2| * depth
   localparam int CLAMP_W     = 40;                    // 2^39 - 1 plus sign
   localparam int PROD_W      = 64;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CLAMP_W-2:0] CLAMP_LIM = {(CLAMP_W-1){1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_DISTANCE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZON_ROW    = 3'd6;

   typedef logic [QUARTER:0][TRIG_FRAC:0] sine_tab_type;

   // Shift-and-subtract unsigned division, used only while building the table
   function automatic longint unsigned long_div(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine, Q22, Taylor series in Q30 with truncated terms
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type      tab;
      longint unsigned   xq;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint            sum;
      longint            r;
      for (int k = 0; k <= QUARTER; k++) begin
         xq   = (longint'(k) * 64'h6487ED511) >> ANGLE_BITS;
         x    = (xq + 64'd2) >> 2;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = long_div((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         r = (sum + 128) >>> 8;
         if (r > (longint'(1) << TRIG_FRAC)) r = longint'(1) << TRIG_FRAC;
         tab[k] = r[TRIG_FRAC:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

### hdl/ground_plane_perspective_project.sv
// Ground-plane perspective projection, one screen pixel per transaction.
//
// Request channel (req_valid/req_stall) carries pixel_col and pixel_row; the
// response channel (rsp_valid/rsp_stall) returns world_x, world_y (Q16.16,
// saturated) and on_ground. Pixels at or above the horizon row return
// on_ground = 0 with zero coordinates.
//
// Stages in order: entry stage, distance*height multiply, a 43-stage
// restoring divider for depth, the lateral multiply, a 56-stage restoring
// divider for the lateral offset, then clamp, rotate multiply, round/sum and
// camera add/saturate. The two bit-per-stage dividers set the depth. One
// transaction is accepted every cycle while the response side takes results.
//
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and req_stall rises; nothing is dropped or repeated.
// Reset is synchronous: it empties the pipeline and loads register defaults.
// Registers are written through csr_write/csr_index/csr_data; write them only
// while no transaction is in flight.
module ground_plane_perspective_project
   import gpp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [PIX_W-1:0]           req_pixel_col,
   input  logic [PIX_W-1:0]           req_pixel_row,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_W-1:0]  rsp_world_x,
   output logic signed [COORD_W-1:0]  rsp_world_y,
   output logic                       rsp_on_ground,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COORD_W-1:0]         csr_data
);

   // Configuration registers
   logic signed [COORD_W-1:0]   camera_x_ff;
   logic signed [COORD_W-1:0]   camera_y_ff;
   logic [ANGLE_BITS-1:0]       camera_heading_ff;
   logic [HEIGHT_W-1:0]         camera_height_ff;
   logic [PIX_W-1:0]            view_width_ff;
   logic [PIX_W-1:0]            view_distance_ff;
   logic signed [HORIZON_W-1:0] horizon_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff       <= '0;
         camera_y_ff       <= '0;
         camera_heading_ff <= '0;
         camera_height_ff  <= HEIGHT_W'(65536);
         view_width_ff     <= PIX_W'(320);
         view_distance_ff  <= PIX_W'(256);
         horizon_row_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CAMERA_X:       camera_x_ff       <= csr_data;
            REG_CAMERA_Y:       camera_y_ff       <= csr_data;
            REG_CAMERA_HEADING: camera_heading_ff <= csr_data[ANGLE_BITS-1:0];
            REG_CAMERA_HEIGHT:  camera_height_ff  <= csr_data[HEIGHT_W-1:0];
            REG_VIEW_WIDTH:     view_width_ff     <= csr_data[PIX_W-1:0];
            REG_VIEW_DISTANCE:  view_distance_ff  <= csr_data[PIX_W-1:0];
            REG_HORIZON_ROW:    horizon_row_ff    <= csr_data[HORIZON_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance: freeze everything while a result waits on a stall
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Sine and cosine of the heading, registered (user must change heading only when idle; not enforced)
   logic signed [TRIG_W-1:0] sin_ff, sin_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in;

   function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-3:0] r;
      logic [ANGLE_BITS-2:0] idx;
      logic [TRIG_FRAC:0]    v;
      r   = a[ANGLE_BITS-3:0];
      idx = a[ANGLE_BITS-2] ? ((ANGLE_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      v   = SINE_TAB[idx];
      return a[ANGLE_BITS-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   always_comb begin
      sin_in = sine_lookup(camera_heading_ff);
      cos_in = sine_lookup(camera_heading_ff + ANGLE_BITS'(QUARTER));
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   // Entry stage: column offset (one fraction bit) and row offset
   logic                    s0_vld_ff;
   logic                    s0_on_ff, s0_on_in;
   logic                    s0_neg_ff;
   logic [DEN_W-1:0]        s0_ax_ff, s0_ax_in;
   logic [DEN_W-1:0]        s0_ry_ff;
   logic signed [OFS_W-1:0] rx2_in, ry_in;

   always_comb begin
      rx2_in   = $signed({1'b0, req_pixel_col, 1'b0}) - $signed({2'b00, view_width_ff});
      ry_in    = $signed({2'b00, req_pixel_row}) - OFS_W'(horizon_row_ff);
      s0_on_in = !ry_in[OFS_W-1] && (ry_in != '0);
      s0_ax_in = rx2_in[OFS_W-1] ? DEN_W'(-rx2_in) : DEN_W'(rx2_in);
   end

   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else if (advance) s0_vld_ff <= req_valid;
      if (advance) begin
         s0_on_ff  <= s0_on_in;
         s0_neg_ff <= rx2_in[OFS_W-1];
         s0_ax_ff  <= s0_ax_in;
         s0_ry_ff  <= s0_on_in ? ry_in[DEN_W-1:0] : DEN_W'(1);
      end
   end

   // Depth divider: (distance * height) / row offset, one quotient bit a stage
   logic [NUM1_W:0]     d1_vld_ff;
   logic                d1_on_ff  [0:NUM1_W];
   logic                d1_neg_ff [0:NUM1_W];
   logic [DEN_W-1:0]    d1_ax_ff  [0:NUM1_W];
   logic [DEN_W-1:0]    d1_den_ff [0:NUM1_W];
   logic [DEN_W-1:0]    d1_rem_ff [0:NUM1_W];
   logic [NUM1_W-1:0]   d1_qd_ff  [0:NUM1_W];

   always_ff @(posedge clock) begin
      if (reset) d1_vld_ff[0] <= 1'b0;
      else if (advance) d1_vld_ff[0] <= s0_vld_ff;
      if (advance) begin
         d1_on_ff[0]  <= s0_on_ff;
         d1_neg_ff[0] <= s0_neg_ff;
         d1_ax_ff[0]  <= s0_ax_ff;
         d1_den_ff[0] <= s0_ry_ff;
         d1_rem_ff[0] <= '0;
         d1_qd_ff[0]  <= NUM1_W'(view_distance_ff * camera_height_ff);
      end
   end

   for (genvar i = 1; i <= NUM1_W; i++) begin : g_div1
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      assign trial  = {d1_rem_ff[i-1], d1_qd_ff[i-1][NUM1_W-1]};
      assign take   = trial >= {1'b0, d1_den_ff[i-1]};
      assign rem_in = take ? DEN_W'(trial - {1'b0, d1_den_ff[i-1]}) : trial[DEN_W-1:0];
      always_ff @(posedge clock) begin
         if (reset) d1_vld_ff[i] <= 1'b0;
         else if (advance) d1_vld_ff[i] <= d1_vld_ff[i-1];
         if (advance) begin
            d1_on_ff[i]  <= d1_on_ff[i-1];
            d1_neg_ff[i] <= d1_neg_ff[i-1];
            d1_ax_ff[i]  <= d1_ax_ff[i-1];
            d1_den_ff[i] <= d1_den_ff[i-1];
            d1_rem_ff[i] <= rem_in;
            d1_qd_ff[i]  <= {d1_qd_ff[i-1][NUM1_W-2:0], take};
         end
      end
   end

   // Lateral numerator |rx2| * depth, and clamped depth
   logic [NUM1_W-1:0]   depth_u;
   logic [CLAMP_W-2:0]  depth_clamp_in;
   assign depth_u        = d1_qd_ff[NUM1_W];
   assign depth_clamp_in = (depth_u > NUM1_W'(CLAMP_LIM)) ? CLAMP_LIM : depth_u[CLAMP_W-2:0];

   logic [NUM2_W:0]     d2_vld_ff;
   logic                d2_on_ff    [0:NUM2_W];
   logic                d2_neg_ff   [0:NUM2_W];
   logic [CLAMP_W-2:0]  d2_depth_ff [0:NUM2_W];
   logic [DEN_W-1:0]    d2_rem_ff   [0:NUM2_W];
   logic [NUM2_W-1:0]   d2_qd_ff    [0:NUM2_W];
   logic [DEN_W-1:0]    d2_den;
   assign d2_den = {view_distance_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) d2_vld_ff[0] <= 1'b0;
      else if (advance) d2_vld_ff[0] <= d1_vld_ff[NUM1_W];
      if (advance) begin
         d2_on_ff[0]    <= d1_on_ff[NUM1_W];
         d2_neg_ff[0]   <= d1_neg_ff[NUM1_W];
         d2_depth_ff[0] <= depth_clamp_in;
         d2_rem_ff[0]   <= '0;
         d2_qd_ff[0]    <= NUM2_W'(d1_ax_ff[NUM1_W] * depth_u);
      end
   end

   // Lateral divider: numerator / (2 * distance)
   for (genvar i = 1; i <= NUM2_W; i++) begin : g_div2
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      assign trial  = {d2_rem_ff[i-1], d2_qd_ff[i-1][NUM2_W-1]};
      assign take   = trial >= {1'b0, d2_den};
      assign rem_in = take ? DEN_W'(trial - {1'b0, d2_den}) : trial[DEN_W-1:0];
      always_ff @(posedge clock) begin
         if (reset) d2_vld_ff[i] <= 1'b0;
         else if (advance) d2_vld_ff[i] <= d2_vld_ff[i-1];
         if (advance) begin
            d2_on_ff[i]    <= d2_on_ff[i-1];
            d2_neg_ff[i]   <= d2_neg_ff[i-1];
            d2_depth_ff[i] <= d2_depth_ff[i-1];
            d2_rem_ff[i]   <= rem_in;
            d2_qd_ff[i]    <= {d2_qd_ff[i-1][NUM2_W-2:0], take};
         end
      end
   end

   // Clamp stage: signed lateral and depth; zero distance gives no offset
   logic                      c_vld_ff, c_on_ff;
   logic signed [CLAMP_W:0]   c_lat_ff, c_lat_in;
   logic signed [CLAMP_W:0]   c_dep_ff;
   logic [NUM2_W-1:0]         mag;
   logic [CLAMP_W-2:0]        mag_clamp;

   always_comb begin
      mag       = d2_qd_ff[NUM2_W];
      mag_clamp = (mag > NUM2_W'(CLAMP_LIM)) ? CLAMP_LIM : mag[CLAMP_W-2:0];
      if (view_distance_ff == '0) mag_clamp = '0;
      c_lat_in  = d2_neg_ff[NUM2_W] ? -$signed({2'b00, mag_clamp})
                                    : $signed({2'b00, mag_clamp});
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= d2_vld_ff[NUM2_W];
      if (advance) begin
         c_on_ff  <= d2_on_ff[NUM2_W];
         c_lat_ff <= c_lat_in;
         c_dep_ff <= $signed({2'b00, d2_depth_ff[NUM2_W]});
      end
   end

   // Rotation products
   logic                     p_vld_ff, p_on_ff;
   logic signed [PROD_W-1:0] p_lc_ff, p_ds_ff, p_ls_ff, p_dc_ff;

   always_ff @(posedge clock) begin
      if (reset) p_vld_ff <= 1'b0;
      else if (advance) p_vld_ff <= c_vld_ff;
      if (advance) begin
         p_on_ff <= c_on_ff;
         p_lc_ff <= PROD_W'(c_lat_ff * cos_ff);
         p_ds_ff <= PROD_W'(c_dep_ff * sin_ff);
         p_ls_ff <= PROD_W'(c_lat_ff * sin_ff);
         p_dc_ff <= PROD_W'(c_dep_ff * cos_ff);
      end
   end

   // Sums with rounding half added
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (TRIG_FRAC - 1);
   logic                     s_vld_ff, s_on_ff;
   logic signed [PROD_W-1:0] s_x_ff, s_y_ff;

   always_ff @(posedge clock) begin
      if (reset) s_vld_ff <= 1'b0;
      else if (advance) s_vld_ff <= p_vld_ff;
      if (advance) begin
         s_on_ff <= p_on_ff;
         s_x_ff  <= p_lc_ff + p_ds_ff + ROUND_HALF;
         s_y_ff  <= p_ls_ff - p_dc_ff + ROUND_HALF;
      end
   end

   // Floor to Q16.16, add camera, saturate
   localparam int SUM_W = PROD_W - TRIG_FRAC + 2;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7FFFFFFF);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-33'sh80000000);

   function automatic logic signed [COORD_W-1:0] add_sat(
      input logic signed [PROD_W-1:0]  v,
      input logic signed [COORD_W-1:0] cam
   );
      logic signed [SUM_W-1:0] t;
      t = SUM_W'(v >>> TRIG_FRAC) + SUM_W'(cam);
      if (t > SAT_MAX) t = SAT_MAX;
      if (t < SAT_MIN) t = SAT_MIN;
      return t[COORD_W-1:0];
   endfunction

   logic                      o_vld_ff, o_on_ff;
   logic signed [COORD_W-1:0] o_x_ff, o_y_ff;

   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else if (advance) o_vld_ff <= s_vld_ff;
      if (advance) begin
         o_on_ff <= s_on_ff;
         o_x_ff  <= s_on_ff ? add_sat(s_x_ff, camera_x_ff) : '0;
         o_y_ff  <= s_on_ff ? add_sat(s_y_ff, camera_y_ff) : '0;
      end
   end

   assign rsp_valid     = o_vld_ff;
   assign rsp_world_x   = o_x_ff;
   assign rsp_world_y   = o_y_ff;
   assign rsp_on_ground = o_on_ff;

   // Checks
   a_off_ground_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_on_ground |-> (rsp_world_x == '0) && (rsp_world_y == '0))
      else $error("off-ground result with nonzero coordinates");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(d1_vld_ff) && $stable(d2_vld_ff))
      else $error("pipeline moved while frozen");

   a_div1_rem: assert property (@(posedge clock) disable iff (reset)
      d1_vld_ff[NUM1_W] |-> d1_rem_ff[NUM1_W] < d1_den_ff[NUM1_W])
      else $error("depth divider remainder out of range");

endmodule

### verif/tb_top.sv
module tb_top
   import gpp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic                      on_ground;
   } ground_point_type;

   localparam int PIPE_DRAIN = 130;
   localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam longint LIM39 = (longint'(1) << 39) - 1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [PIX_W-1:0]          req_pixel_col;
   logic [PIX_W-1:0]          req_pixel_row;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [COORD_W-1:0] rsp_world_x;
   logic signed [COORD_W-1:0] rsp_world_y;
   logic                      rsp_on_ground;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [COORD_W-1:0]        csr_data;

   // shadow copy of the camera registers
   logic signed [COORD_W-1:0]   cam_x;
   logic signed [COORD_W-1:0]   cam_y;
   logic [ANGLE_BITS-1:0]       cam_heading;
   logic [HEIGHT_W-1:0]         cam_height;
   logic [PIX_W-1:0]            scr_width;
   logic [PIX_W-1:0]            eye_dist;
   logic signed [HORIZON_W-1:0] horizon;

   longint           quarter_wave [0:QUARTER];
   ground_point_type pending_points [$];
   int               errors;
   bit               idle_on;
   int               hold_cycles;

   ground_plane_perspective_project dut (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // quarter-wave sine in Q22, Taylor series evaluated in Q30
   function automatic void fill_quarter_wave();
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned tm;
      longint          acc;
      longint          q22;
      for (int k = 0; k <= QUARTER; k++) begin
         ang    = ((longint'(k) * 64'h6487ED511) >> ANGLE_BITS);
         ang    = (ang + 64'd2) >> 2;
         ang_sq = (ang * ang) >> 30;
         tm     = ang;
         acc    = longint'(ang);
         for (int n = 1; n <= 10; n++) begin
            tm = ((tm * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - longint'(tm) : acc + longint'(tm);
         end
         if (acc < 0) acc = 0;
         q22 = (acc + 128) >>> 8;
         if (q22 > (longint'(1) << TRIG_FRAC)) q22 = longint'(1) << TRIG_FRAC;
         quarter_wave[k] = q22;
      end
   endfunction

   function automatic longint sine_at(logic [ANGLE_BITS-1:0] a);
      logic [1:0]            quad;
      logic [ANGLE_BITS-3:0] ofs;
      longint                v;
      quad = a[ANGLE_BITS-1 -: 2];
      ofs  = a[ANGLE_BITS-3:0];
      v    = quad[0] ? quarter_wave[QUARTER - ofs] : quarter_wave[ofs];
      return quad[1] ? -v : v;
   endfunction

   function automatic longint clamp39(longint v);
      if (v > LIM39) return LIM39;
      if (v < -LIM39) return -LIM39;
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[COORD_W-1:0];
   endfunction

   // project one pixel onto the ground plane
   function automatic ground_point_type project_pixel(logic [PIX_W-1:0] col,
                                                      logic [PIX_W-1:0] row);
      ground_point_type pt;
      longint           rx2;
      longint           ry;
      longint unsigned  depth_u;
      longint unsigned  mag;
      longint unsigned  ax;
      longint           depth;
      longint           lateral;
      longint           sn;
      longint           cs;
      pt.world_x   = '0;
      pt.world_y   = '0;
      pt.on_ground = 1'b0;
      rx2 = 2 * longint'(col) - longint'(scr_width);
      ry  = longint'(row) - longint'(horizon);
      if (ry < 1) return pt;
      depth_u = (longint'(eye_dist) * longint'(cam_height)) / ry;
      if (eye_dist == 0) mag = 0;
      else begin
         ax  = (rx2 < 0) ? -rx2 : rx2;
         mag = (ax * depth_u) / (2 * longint'(eye_dist));
      end
      depth   = clamp39(longint'(depth_u));
      lateral = clamp39(rx2 < 0 ? -longint'(mag) : longint'(mag));
      sn = sine_at(cam_heading);
      cs = sine_at(cam_heading + ANGLE_BITS'(QUARTER));
      // rounding half up is a floor of the biased value
      pt.world_x = sat_coord(longint'(cam_x) +
                   ((lateral * cs + depth * sn + (longint'(1) << 21)) >>> TRIG_FRAC));
      pt.world_y = sat_coord(longint'(cam_y) +
                   ((lateral * sn - depth * cs + (longint'(1) << 21)) >>> TRIG_FRAC));
      pt.on_ground = 1'b1;
      return pt;
   endfunction

   // response side flow control, with optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 36);
      end
   end

   // response checker; sampled mid-cycle, accepted at the following edge
   always @(negedge clock) begin
      ground_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_world_x !== want.world_x) begin
               $error("world_x expected %0d actual %0d", want.world_x, rsp_world_x);
               errors++;
            end
            if (rsp_world_y !== want.world_y) begin
               $error("world_y expected %0d actual %0d", want.world_y, rsp_world_y);
               errors++;
            end
            if (rsp_on_ground !== want.on_ground) begin
               $error("on_ground expected %0b actual %0b", want.on_ground, rsp_on_ground);
               errors++;
            end
         end
      end
   end

   // offer one pixel and wait until it is taken
   task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      bit stalled;
      while (idle_on && ($urandom_range(99) < 36)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      pending_points.push_back(project_pixel(col, row));
   endtask

   // stop offering and let everything in flight come out
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         REG_CAMERA_X:       cam_x       = val;
         REG_CAMERA_Y:       cam_y       = val;
         REG_CAMERA_HEADING: cam_heading = val[ANGLE_BITS-1:0];
         REG_CAMERA_HEIGHT:  cam_height  = val[HEIGHT_W-1:0];
         REG_VIEW_WIDTH:     scr_width   = val[PIX_W-1:0];
         REG_VIEW_DISTANCE:  eye_dist    = val[PIX_W-1:0];
         REG_HORIZON_ROW:    horizon     = val[HORIZON_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_camera(logic [31:0] x, logic [31:0] y, logic [31:0] hd,
                              logic [31:0] ht, logic [31:0] w, logic [31:0] d,
                              logic [31:0] hz);
      write_reg(REG_CAMERA_X, x);
      write_reg(REG_CAMERA_Y, y);
      write_reg(REG_CAMERA_HEADING, hd);
      write_reg(REG_CAMERA_HEIGHT, ht);
      write_reg(REG_VIEW_WIDTH, w);
      write_reg(REG_VIEW_DISTANCE, d);
      write_reg(REG_HORIZON_ROW, hz);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // reset defaults: corners of the screen, rows on and below the horizon
   task automatic test_reset_defaults();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd160, 12'd1);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd319, 12'd120);
      drain_pipe();
   endtask

   // extreme settings: saturation, zero distance, zero width, horizon limits
   task automatic test_extremes();
      load_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF,
                  32'd4095, 32'd4095, 32'd0);
      send_pixel(12'd0, 12'd1);
      send_pixel(12'd4095, 12'd1);
      send_pixel(12'd2048, 12'd4095);
      drain_pipe();
      load_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'd512, 32'h7FFF_FFFF,
                  32'd1, 32'd1, 32'h1000);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      drain_pipe();
      load_camera(32'h0001_0000, 32'hFFFF_0000, 32'd256, 32'd0,
                  32'd0, 32'd0, 32'h0FFF);
      send_pixel(12'd100, 12'd4095);
      send_pixel(12'd100, 12'd4094);
      drain_pipe();
      load_camera(32'd0, 32'd0, 32'd1023, 32'h0010_0000,
                  32'd0, 32'd64, 32'd0);
      send_pixel(12'd0, 12'd5);
      send_pixel(12'd4095, 12'd5);
      drain_pipe();
   endtask

   // headings on or near several quadrant boundaries of the heading
   task automatic test_headings();
      logic [9:0] hd [8] = '{10'd0, 10'd1, 10'd255, 10'd256, 10'd511,
                             10'd768, 10'd800, 10'd1023};
      foreach (hd[i]) begin
         load_camera(32'h0100_0000, 32'hFF00_0000, 32'(hd[i]), 32'h0003_8000,
                     32'd640, 32'd300, 32'd200);
         send_pixel(12'd13, 12'd260);
         send_pixel(12'd630, 12'd479);
         drain_pipe();
      end
   endtask

   // random settings, random pixels, one stretch with no idling
   task automatic test_random_scenes();
      logic [31:0] hz;
      logic [31:0] ht;
      for (int phase = 0; phase < 13; phase++) begin
         idle_on = (phase != 4);
         ht = (phase % 3 == 0) ? $urandom() : $urandom_range(32'h0040_0000);
         hz = (phase % 2 == 0) ? $urandom_range(8191) : $urandom_range(600);
         load_camera($urandom(), $urandom(), $urandom_range(1023), ht,
                     $urandom_range(4095), $urandom_range(4095), hz);
         for (int n = 0; n < 100; n++)
            send_pixel(PIX_W'($urandom_range(4095)),
                       ($urandom_range(3) == 0) ? PIX_W'($urandom_range(4095))
                                                : PIX_W'($urandom_range(700)));
         drain_pipe();
      end
      idle_on = 1'b1;
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      load_camera(32'h0020_0000, 32'h0030_0000, 32'd100, 32'h0002_0000,
                  32'd320, 32'd256, 32'd100);
      idle_on = 1'b0;
      hold_cycles = 300;
      for (int n = 0; n < 200; n++)
         send_pixel(PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)));
      idle_on = 1'b1;
      drain_pipe();
      for (int n = 0; n < 40; n++)
         send_pixel(PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)));
      drain_pipe();
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_pixel_col <= '0;
      req_pixel_row <= '0;
      rsp_stall     <= 1'b0;
      csr_write     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      errors      = 0;
      idle_on     = 1'b1;
      hold_cycles = 0;
      cam_x       = '0;
      cam_y       = '0;
      cam_heading = '0;
      cam_height  = 31'd65536;
      scr_width   = 12'd320;
      eye_dist    = 12'd256;
      horizon     = '0;
      fill_quarter_wave();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_reset_defaults();
      test_extremes();
      test_headings();
      test_random_scenes();
      test_backpressure();

      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
